@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

@@ design/csa_pkg.sv @@
// Types and constants of the cpu slot allocator.
package csa_pkg;

   localparam int COUNT_W  = 7;
   localparam int CPU_ID_W = 6;

   localparam logic [1:0] MODE_ALLOC     = 2'd0;
   localparam logic [1:0] MODE_FREE_CPU  = 2'd1;
   localparam logic [1:0] MODE_FREE_SLOT = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REFUSED  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [COUNT_W-1:0]  count;
      logic [CPU_ID_W-1:0] cpu_id;
   } csa_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                has_cpu;
      logic [CPU_ID_W-1:0] cpu_out;
      logic                last;
   } csa_rsp_type;

   typedef enum logic [1:0] {
      CMD_SLOT_TAKE,
      CMD_ALLOC,
      CMD_PUSH,
      CMD_SLOT_GIVE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [COUNT_W-1:0]  count;
      logic [CPU_ID_W-1:0] cpu_id;
   } csa_cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic        valid;
      csa_cmd_type cmd;
   } csa_qhead_type;

   typedef enum logic {
      BK_IDLE,
      BK_POP
   } back_state_type;

endpackage

@@ design/csa_front.sv @@
// Front end: takes request beats, decodes them into commands, holds a 2-entry queue.
`include "assert_macros.svh"

module csa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  csa_pkg::csa_req_type req_payload,
   output csa_pkg::csa_qhead_type q_head,
   input  logic                 q_pop
);

   csa_pkg::csa_cmd_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;
   csa_pkg::csa_cmd_type dec_cmd;
   logic                 dec_keep;
   logic                 push;

   always_comb begin
      dec_cmd.count  = req_payload.count;
      dec_cmd.cpu_id = req_payload.cpu_id;
      dec_keep       = 1'b1;
      case (req_payload.mode)
         csa_pkg::MODE_ALLOC: begin
            dec_cmd.kind = (req_payload.count == '0) ? csa_pkg::CMD_SLOT_TAKE
                                                     : csa_pkg::CMD_ALLOC;
         end
         csa_pkg::MODE_FREE_CPU:  dec_cmd.kind = csa_pkg::CMD_PUSH;
         csa_pkg::MODE_FREE_SLOT: dec_cmd.kind = csa_pkg::CMD_SLOT_GIVE;
         default: begin
            // unused mode: beat is taken and dropped
            dec_cmd.kind = csa_pkg::CMD_SLOT_GIVE;
            dec_keep     = 1'b0;
         end
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready && dec_keep;

   assign q_head.valid = (fill_ff != 2'd0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= 2'd2)
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, fill_ff != 2'd0)
   `ASSERT_ALWAYS(a_ptr_fill, clock, reset, (fill_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))

endmodule

@@ design/csa_back.sv @@
// Back end: free-id stack, zero-cost slot counter and the result register.
`include "assert_macros.svh"

module csa_back #(
   parameter int MAX_CPUS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [csa_pkg::COUNT_W-1:0]   csr_wr_data,
   input  csa_pkg::csa_qhead_type        q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output csa_pkg::csa_rsp_type          rsp_payload
);

   localparam int DW = $clog2(MAX_CPUS + 1);
   localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
   localparam int ZW = DW + 1;

   logic [csa_pkg::CPU_ID_W-1:0] stack_mem [MAX_CPUS];
   logic [MAX_CPUS-1:0]          ent_vld_ff;

   csa_pkg::back_state_type      state_ff, state_in;
   logic [DW-1:0]                cpu_count_ff;
   logic [DW-1:0]                depth_ff, depth_in;
   logic [ZW-1:0]                zero_ff, zero_in;
   logic [csa_pkg::COUNT_W-1:0]  remain_ff, remain_in;

   logic                         rsp_valid_ff;
   logic [1:0]                   status_ff, status_in;
   logic                         has_ff, has_in;
   logic                         last_ff, last_in;
   logic [csa_pkg::CPU_ID_W-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr_ff;
   logic                         rd_vld_ff;

   logic                         out_free;
   logic                         load;
   logic                         mem_we;
   logic                         mem_re;
   logic [DW-1:0]                depth_m1;
   logic [AW-1:0]                rd_addr;
   logic [AW-1:0]                wr_addr;
   logic [ZW-1:0]                slot_limit;
   logic [DW-1:0]                cfg_n;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign depth_m1   = depth_ff - DW'(1);
   assign rd_addr    = depth_m1[AW-1:0];
   assign wr_addr    = depth_ff[AW-1:0];
   assign slot_limit = {cpu_count_ff, 1'b1};

   // clamp the written cpu count into 1..MAX_CPUS
   always_comb begin
      if (csr_wr_data == '0) begin
         cfg_n = DW'(1);
      end else if (csr_wr_data > csa_pkg::COUNT_W'(MAX_CPUS)) begin
         cfg_n = DW'(MAX_CPUS);
      end else begin
         cfg_n = DW'(csr_wr_data);
      end
   end

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      zero_in   = zero_ff;
      remain_in = remain_ff;
      status_in = csa_pkg::STATUS_OK;
      has_in    = 1'b0;
      last_in   = 1'b1;
      q_pop     = 1'b0;
      load      = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         csa_pkg::BK_IDLE: begin
            if (q_head.valid && out_free) begin
               q_pop = 1'b1;
               load  = 1'b1;
               case (q_head.cmd.kind)
                  csa_pkg::CMD_SLOT_TAKE: begin
                     if (zero_ff != '0) begin
                        zero_in = zero_ff - ZW'(1);
                     end else begin
                        status_in = csa_pkg::STATUS_REFUSED;
                     end
                  end
                  csa_pkg::CMD_ALLOC: begin
                     if (q_head.cmd.count > csa_pkg::COUNT_W'(depth_ff)) begin
                        status_in = csa_pkg::STATUS_REFUSED;
                     end else begin
                        has_in    = 1'b1;
                        mem_re    = 1'b1;
                        depth_in  = depth_m1;
                        remain_in = q_head.cmd.count - csa_pkg::COUNT_W'(1);
                        last_in   = (q_head.cmd.count == csa_pkg::COUNT_W'(1));
                        if (!last_in) begin
                           state_in = csa_pkg::BK_POP;
                        end
                     end
                  end
                  csa_pkg::CMD_PUSH: begin
                     if (depth_ff >= cpu_count_ff) begin
                        status_in = csa_pkg::STATUS_OVERFLOW;
                     end else begin
                        mem_we   = 1'b1;
                        depth_in = depth_ff + DW'(1);
                     end
                  end
                  csa_pkg::CMD_SLOT_GIVE: begin
                     if (zero_ff >= slot_limit) begin
                        status_in = csa_pkg::STATUS_OVERFLOW;
                     end else begin
                        zero_in = zero_ff + ZW'(1);
                     end
                  end
                  default: begin
                     status_in = csa_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         csa_pkg::BK_POP: begin
            if (out_free) begin
               load      = 1'b1;
               has_in    = 1'b1;
               mem_re    = 1'b1;
               depth_in  = depth_m1;
               remain_in = remain_ff - csa_pkg::COUNT_W'(1);
               last_in   = (remain_ff == csa_pkg::COUNT_W'(1));
               if (last_in) begin
                  state_in = csa_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = csa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         state_ff <= csa_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_count_ff <= DW'(MAX_CPUS);
         depth_ff     <= DW'(MAX_CPUS);
         zero_ff      <= {DW'(MAX_CPUS), 1'b1};
         ent_vld_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_wr_en) begin
         cpu_count_ff <= cfg_n;
         depth_ff     <= cfg_n;
         zero_ff      <= {cfg_n, 1'b1};
         ent_vld_ff   <= '0;
         remain_ff    <= '0;
      end else begin
         depth_ff  <= depth_in;
         zero_ff   <= zero_in;
         remain_ff <= remain_in;
         if (mem_we) begin
            ent_vld_ff[wr_addr] <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stack storage; an entry never pushed since refill reads as its own index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= q_head.cmd.cpu_id;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_addr];
         rd_addr_ff <= rd_addr;
         rd_vld_ff  <= ent_vld_ff[rd_addr];
      end
      if (load) begin
         status_ff <= status_in;
         has_ff    <= has_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload.status  = status_ff;
   assign rsp_payload.has_cpu = has_ff;
   assign rsp_payload.last    = last_ff;
   assign rsp_payload.cpu_out = !has_ff   ? '0 :
                                rd_vld_ff ? rd_data_ff :
                                            csa_pkg::CPU_ID_W'(rd_addr_ff);

   `ASSERT_ALWAYS(a_depth_bound, clock, reset, depth_ff <= cpu_count_ff)
   `ASSERT_ALWAYS(a_zero_bound, clock, reset, zero_ff <= slot_limit)
   `ASSERT_IMPLIES(a_pop_remain, clock, reset, state_ff == csa_pkg::BK_POP,
      (remain_ff != '0) && (remain_ff <= csa_pkg::COUNT_W'(depth_ff)))
   `ASSERT_IMPLIES(a_grant_ok, clock, reset, rsp_valid_ff && has_ff,
      status_ff == csa_pkg::STATUS_OK)

endmodule

@@ design/cpu_slot_allocator.sv @@
// Top level of the cpu slot allocator: decode front end, command queue, stack back end.
//
//   port group   dir   handshake          beat contents
//   req_*        in    req_valid/ready    mode, count, cpu_id
//   rsp_*        out   rsp_valid/ready    status, has_cpu, cpu_out, last
//   csr_*        in    csr_wr_en only     cpu_count (7 bits)
//
// A request beat is registered in the 2-entry queue, whose head the back end reads.
// Single-result requests give one result beat; an allocate of n ids gives n beats,
// one per cycle while rsp_ready allows, one stack pop (one memory read port) each.
// Reset and cpu count writes refill the stack at once through per-entry valid bits.
// rsp_ready low stalls only the back end; the queue keeps accepting until full.

module cpu_slot_allocator #(
   parameter int MAX_CPUS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  csa_pkg::csa_req_type        req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output csa_pkg::csa_rsp_type        rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [csa_pkg::COUNT_W-1:0] csr_wr_data
);

   csa_pkg::csa_qhead_type q_head;
   logic                   q_pop;

   csa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   csa_back #(
      .MAX_CPUS (MAX_CPUS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/sv/cpu_slot_allocator_test.sv @@
`timescale 1ns / 100ps
// Self-checking regression bench for the cpu slot allocator.
module cpu_slot_allocator_test;

   localparam int CPU_SLOTS = 64;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic {
      ROW_BEAT,
      ROW_CPU_COUNT
   } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csa_pkg::csa_req_type beat;
      bit                   typed;
      logic [1:0]           status;
   } script_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   csa_pkg::csa_req_type        req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   csa_pkg::csa_rsp_type        rsp_payload;
   logic                        csr_wr_en = 1'b0;
   logic [csa_pkg::COUNT_W-1:0] csr_wr_data = '0;

   // Shadow copy of the allocator state
   logic [csa_pkg::CPU_ID_W-1:0] free_ids [CPU_SLOTS];
   int                           ids_free;
   int                           slots_free;
   int                           cpus;
   logic [csa_pkg::CPU_ID_W-1:0] held_ids [$];

   csa_pkg::csa_rsp_type fresh_outcomes [$];
   csa_pkg::csa_rsp_type outcomes_due [$];
   script_row_type       script [$];

   int error_count = 0;
   int sender_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   cpu_slot_allocator #(
      .MAX_CPUS(CPU_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("cpu_slot_allocator regression: fail");
      $finish;
   end

   function automatic csa_pkg::csa_rsp_type outcome(input logic [1:0] status,
                                                    input logic has_cpu,
                                                    input logic [csa_pkg::CPU_ID_W-1:0] id,
                                                    input logic last);
      csa_pkg::csa_rsp_type r;
      r.status = status;
      r.has_cpu = has_cpu;
      r.cpu_out = id;
      r.last = last;
      return r;
   endfunction

   function automatic void owe(input csa_pkg::csa_rsp_type r);
      fresh_outcomes.insert(fresh_outcomes.size(), r);
   endfunction

   function automatic void reload_cpus(input logic [csa_pkg::COUNT_W-1:0] value);
      if (value == 0)
         cpus = 1;
      else if (int'(value) > CPU_SLOTS)
         cpus = CPU_SLOTS;
      else
         cpus = int'(value);
      for (int i = 0; i < CPU_SLOTS; i++)
         free_ids[i] = csa_pkg::CPU_ID_W'(i);
      ids_free = cpus;
      slots_free = 2 * cpus + 1;
      held_ids.delete();
   endfunction

   // Results one accepted beat causes; leaves them in fresh_outcomes.
   function automatic void track_allocation(input csa_pkg::csa_req_type beat);
      fresh_outcomes.delete();
      case (beat.mode)
         csa_pkg::MODE_ALLOC: begin
            if (beat.count == 0) begin
               if (slots_free > 0) begin
                  slots_free--;
                  owe(outcome(csa_pkg::STATUS_OK, 1'b0, '0, 1'b1));
               end else begin
                  owe(outcome(csa_pkg::STATUS_REFUSED, 1'b0, '0, 1'b1));
               end
            end else if (int'(beat.count) > ids_free) begin
               owe(outcome(csa_pkg::STATUS_REFUSED, 1'b0, '0, 1'b1));
            end else begin
               for (int k = 0; k < int'(beat.count); k++) begin
                  ids_free--;
                  owe(outcome(csa_pkg::STATUS_OK, 1'b1, free_ids[ids_free],
                              k == int'(beat.count) - 1));
                  held_ids.insert(held_ids.size(), free_ids[ids_free]);
               end
            end
         end
         csa_pkg::MODE_FREE_CPU: begin
            if (ids_free >= cpus) begin
               owe(outcome(csa_pkg::STATUS_OVERFLOW, 1'b0, '0, 1'b1));
            end else begin
               free_ids[ids_free] = beat.cpu_id;
               ids_free++;
               owe(outcome(csa_pkg::STATUS_OK, 1'b0, '0, 1'b1));
            end
         end
         csa_pkg::MODE_FREE_SLOT: begin
            if (slots_free >= 2 * cpus + 1) begin
               owe(outcome(csa_pkg::STATUS_OVERFLOW, 1'b0, '0, 1'b1));
            end else begin
               slots_free++;
               owe(outcome(csa_pkg::STATUS_OK, 1'b0, '0, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   // Mostly legal traffic that hands back ids it was granted; some noise.
   function automatic csa_pkg::csa_req_type random_beat();
      csa_pkg::csa_req_type beat;
      int pick;
      int span;
      int slot;
      beat.mode = csa_pkg::MODE_ALLOC;
      beat.count = csa_pkg::COUNT_W'($urandom_range(127));
      beat.cpu_id = csa_pkg::CPU_ID_W'($urandom_range(63));
      pick = int'($urandom_range(99));
      if (pick < 30) begin
         span = (ids_free < 2) ? ids_free : 2;
         if (ids_free == 0)
            beat.count = csa_pkg::COUNT_W'($urandom_range(3, 1));
         else if ($urandom_range(9) == 0)
            beat.count = csa_pkg::COUNT_W'($urandom_range(ids_free, 1));
         else
            beat.count = csa_pkg::COUNT_W'($urandom_range(span, 1));
      end else if (pick < 42) begin
         beat.count = '0;
      end else if (pick < 72) begin
         beat.mode = csa_pkg::MODE_FREE_CPU;
         if (held_ids.size() != 0) begin
            slot = int'($urandom_range(held_ids.size() - 1));
            beat.cpu_id = held_ids[slot];
            held_ids.delete(slot);
         end
      end else if (pick < 84) begin
         beat.mode = csa_pkg::MODE_FREE_SLOT;
      end else if (pick < 90) begin
         beat.mode = csa_pkg::MODE_ALLOC;   // random 7-bit count, mostly refused
      end else if (pick < 95) begin
         beat.mode = MODE_UNUSED;
      end else begin
         beat.mode = 2'($urandom_range(3));
      end
      return beat;
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [1:0] mode,
                                   input logic [csa_pkg::COUNT_W-1:0] count,
                                   input logic [csa_pkg::CPU_ID_W-1:0] id,
                                   input bit typed, input logic [1:0] status);
      script_row_type row;
      row.kind = kind;
      row.beat.mode = mode;
      row.beat.count = count;
      row.beat.cpu_id = id;
      row.typed = typed;
      row.status = status;
      script.insert(script.size(), row);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Called at a clock edge; returns at the edge the beat is taken.
   task automatic send_beat(input csa_pkg::csa_req_type beat, input bit typed,
                            input logic [1:0] status);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      track_allocation(beat);
      if (typed)
         outcomes_due.insert(outcomes_due.size(), outcome(status, 1'b0, '0, 1'b1));
      else
         foreach (fresh_outcomes[i])
            outcomes_due.insert(outcomes_due.size(), fresh_outcomes[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      // settle before a register write or the next burst
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_cpu_count(input logic [csa_pkg::COUNT_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reload_cpus(value);
   endtask

   task automatic run_phase(input logic [csa_pkg::COUNT_W-1:0] n_cpus, input int send_pct,
                            input int recv_pct, input int items, input bit hold);
      csa_pkg::csa_req_type beat;
      int counted;
      counted = 0;
      write_cpu_count(n_cpus);
      sender_idle_pct = send_pct;
      rsp_idle_pct <= recv_pct;
      while (counted < items) begin
         beat = random_beat();
         send_beat(beat, 1'b0, csa_pkg::STATUS_OK);
         if (beat.mode != MODE_UNUSED) begin
            counted++;
            if (hold && counted == 10)
               hold_requests <= hold_requests + 1;
            else if (!hold && counted == items / 2)
               drain();
         end
      end
   endtask

   // Receiver: random backpressure plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      csa_pkg::csa_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t ns: result beat expected none, actual %p", $time,
                     rsp_payload);
            error_count++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("status", int'(want.status), int'(rsp_payload.status));
            check_field("has_cpu", int'(want.has_cpu), int'(rsp_payload.has_cpu));
            check_field("cpu_out", int'(want.cpu_out), int'(rsp_payload.cpu_out));
            check_field("last", int'(want.last), int'(rsp_payload.last));
         end
      end
   end

   initial begin
      reload_cpus(csa_pkg::COUNT_W'(CPU_SLOTS));
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;

      // Reset state: full stack and full slot counter
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_CPU, 7'd0, 6'd63, 1'b1, csa_pkg::STATUS_OVERFLOW);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_SLOT, 7'd127, 6'd0, 1'b1,
              csa_pkg::STATUS_OVERFLOW);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd127, 6'd21, 1'b1, csa_pkg::STATUS_REFUSED);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd65, 6'd42, 1'b1, csa_pkg::STATUS_REFUSED);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd64, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd1, 6'd63, 1'b1, csa_pkg::STATUS_REFUSED);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_CPU, 7'd0, 6'd63, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_CPU, 7'd127, 6'd0, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd2, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, MODE_UNUSED, 7'd127, 6'd63, 1'b0, csa_pkg::STATUS_OK);
      // zero is taken as one cpu: three slots
      add_row(ROW_CPU_COUNT, csa_pkg::MODE_ALLOC, 7'd0, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd0, 6'd63, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd0, 6'd0, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd0, 6'd21, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd0, 6'd42, 1'b1, csa_pkg::STATUS_REFUSED);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_SLOT, 7'd0, 6'd0, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd1, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      // id beyond cpu_count goes back on the stack unchecked
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_CPU, 7'd0, 6'd42, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_CPU, 7'd0, 6'd5, 1'b1, csa_pkg::STATUS_OVERFLOW);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd1, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_CPU_COUNT, csa_pkg::MODE_ALLOC, 7'd127, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd0, 6'd0, 1'b1, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_ALLOC, 7'd3, 6'd0, 1'b0, csa_pkg::STATUS_OK);
      add_row(ROW_BEAT, csa_pkg::MODE_FREE_SLOT, 7'd0, 6'd0, 1'b1, csa_pkg::STATUS_OK);

      sender_idle_pct = 25;
      rsp_idle_pct <= 76;
      foreach (script[i]) begin
         if (script[i].kind == ROW_CPU_COUNT)
            write_cpu_count(script[i].beat.count);
         else
            send_beat(script[i].beat, script[i].typed, script[i].status);
      end

      run_phase(7'd13, 25, 76, 100, 1'b0);
      run_phase(7'd64, 76, 25, 100, 1'b0);
      run_phase(7'd3, 0, 0, 100, 1'b1);

      drain();
      if (error_count == 0)
         $display("cpu_slot_allocator regression: pass");
      else
         $display("cpu_slot_allocator regression: fail");
      $finish;
   end

endmodule
